// File: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, suspended while in reset.
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain condition that must hold on every rising edge out of reset.
`define FFBA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

// File: rtl/ffba_pkg.sv
// Types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned REQ_W  = 25;
  localparam int unsigned POS_W  = 11;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] STS_BAD_FREE   = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_offset;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic              free;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              active;
    logic              found;
    logic [POS_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
    logic              free;
    logic              split_ok;
    logic              prev_free;
    logic              next_free;
  } probe_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_SETFREE,
    CMD_MERGE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [POS_W-1:0]  pos;
    logic [REQ_W-1:0]  need;
    logic              is_free;
    logic [ADDR_W-1:0] off;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/first_fit_block_allocator_core.sv
// Top level of the first-fit heap block allocator with splitting and coalescing.
`default_nettype none
// The heap is tiled by an address-ordered table of MAX_BLOCKS blocks, one per
// cell in a chain; each block is a header of HEADER_BYTES then its payload.
// An allocate transfer rounds its size up to GRAIN_BYTES (add and mask, so
// GRAIN_BYTES must be a power of two), then sends a probe token down the
// chain, one cell per cycle; the first free block large enough is taken and,
// when the rest holds a header plus one grain and the table is not full,
// split. A free transfer probes the same way for the block whose payload
// sits at the given offset, marks it free and merges it with a free
// successor, then with a free predecessor; every split or merge shifts the
// later entries of the table by one place.
// A probed result waits for the token to walk the whole chain; a zero-size
// allocation, and one whose rounded size overflows the request width,
// answer without a probe. One item is in work at a time; the input is
// ready again as soon as its result sits in the output register.
// Results are payload offsets within the heap; status 1 marks a failed or
// zero-size allocation, status 2 a free of an address that is not in use.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEAP_BYTES   = 16777216,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned GRAIN_BYTES  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ffba_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ffba_pkg::out_item_t     out_data_o
);
  import ffba_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIXUP,
    ST_LAUNCH,
    ST_WAIT,
    ST_CMD_A,
    ST_CMD_B,
    ST_CMD_C,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic              kind_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] off_q;
  logic [REQ_W-1:0]  need_q;
  probe_t            hit_q;
  logic              full_q;
  logic [1:0]        status_q;
  logic [ADDR_W-1:0] grant_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  cmd_t   cmd;
  entry_t entry_w [MAX_BLOCKS];
  probe_t probe_w [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] valid_vec;
  logic [MAX_BLOCKS-1:0] token_vec;

  logic [REQ_W:0] need_sum;

  // Round up to the grain; the extra top bit flags a size past the request width.
  assign need_sum = ({1'b0, req_q} + (REQ_W + 1)'(GRAIN_BYTES - 1)) &
                    ~((REQ_W + 1)'(GRAIN_BYTES - 1));

  // Token injected at the head of the chain.
  always_comb begin
    probe_w[0]        = '0;
    probe_w[0].active = (state_q == ST_LAUNCH);
  end

  // Table edit broadcast to every cell.
  always_comb begin
    cmd         = '0;
    cmd.op      = CMD_NOP;
    cmd.pos     = hit_q.idx;
    cmd.need    = need_q;
    cmd.is_free = kind_q;
    cmd.off     = off_q;
    case (state_q)
      ST_CMD_A: begin
        if (kind_q) cmd.op = CMD_SETFREE;
        else if (hit_q.split_ok && !full_q) cmd.op = CMD_SPLIT;
        else cmd.op = CMD_TAKE;
      end
      ST_CMD_B: cmd.op = CMD_MERGE;
      ST_CMD_C: begin
        cmd.op  = CMD_MERGE;
        cmd.pos = hit_q.idx - POS_W'(1);
      end
      default: cmd.op = CMD_NOP;
    endcase
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    entry_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = entry_w[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body
      assign right_w = entry_w[g+1];
    end

    ffba_cell #(
      .Index      (g),
      .HeapBytes  (HEAP_BYTES),
      .HeaderBytes(HEADER_BYTES),
      .GrainBytes (GRAIN_BYTES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .left_i (left_w),
      .right_i(right_w),
      .cmd_i  (cmd),
      .probe_i(probe_w[g]),
      .probe_o(probe_w[g+1]),
      .entry_o(entry_w[g])
    );

    assign valid_vec[g] = entry_w[g].valid;
    assign token_vec[g] = probe_w[g+1].active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= 1'b0;
      req_q       <= '0;
      off_q       <= '0;
      need_q      <= '0;
      hit_q       <= '0;
      full_q      <= 1'b0;
      status_q    <= STS_OK;
      grant_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Result taken; a result handed over in the same cycle refills it below.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= in_data_i.kind;
            req_q    <= in_data_i.request_bytes;
            off_q    <= in_data_i.payload_offset;
            status_q <= STS_OK;
            grant_q  <= '0;
            if (in_data_i.kind) begin
              state_q <= ST_LAUNCH;
            end else if (in_data_i.request_bytes == '0) begin
              status_q <= STS_ALLOC_FAIL;
              state_q  <= ST_DONE;
            end else begin
              state_q <= ST_FIXUP;
            end
          end
        end
        ST_FIXUP: begin
          need_q <= need_sum[REQ_W-1:0];
          if (need_sum[REQ_W]) begin
            // Rounded size beyond any block the heap can hold.
            status_q <= STS_ALLOC_FAIL;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (probe_w[MAX_BLOCKS].active) begin
            hit_q  <= probe_w[MAX_BLOCKS];
            full_q <= entry_w[MAX_BLOCKS-1].valid;
            if (kind_q) begin
              if (!probe_w[MAX_BLOCKS].found || probe_w[MAX_BLOCKS].free) begin
                status_q <= STS_BAD_FREE;
                state_q  <= ST_DONE;
              end else begin
                state_q <= ST_CMD_A;
              end
            end else if (!probe_w[MAX_BLOCKS].found) begin
              status_q <= STS_ALLOC_FAIL;
              state_q  <= ST_DONE;
            end else begin
              grant_q <= ADDR_W'({1'b0, probe_w[MAX_BLOCKS].start} +
                                 REQ_W'(HEADER_BYTES));
              state_q <= ST_CMD_A;
            end
          end
        end
        ST_CMD_A: begin
          if (!kind_q) state_q <= ST_DONE;
          else if (hit_q.next_free) state_q <= ST_CMD_B;
          else if (hit_q.prev_free) state_q <= ST_CMD_C;
          else state_q <= ST_DONE;
        end
        ST_CMD_B: begin
          state_q <= hit_q.prev_free ? ST_CMD_C : ST_DONE;
        end
        ST_CMD_C: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hand over only once the output register is free or being emptied.
          if (!out_valid_q || out_ready_i) begin
            out_data_q.status         <= status_q;
            out_data_q.granted_offset <= grant_q;
            out_valid_q               <= 1'b1;
            state_q                   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Head entry always describes the block at offset zero.
  `FFBA_ASSERT_ALWAYS(a_head_valid, valid_vec[0], "head entry lost")
  // Valid entries form an unbroken run from the head.
  `FFBA_ASSERT_ALWAYS(a_valid_run, (valid_vec & (valid_vec + 1'b1)) == '0, "gap in entry table")
  // At most one probe token in flight, and never during a table edit.
  `FFBA_ASSERT_ALWAYS(a_one_token, $countones(token_vec) <= 1, "several probe tokens")
  `FFBA_ASSERT(a_edit_quiet, (cmd.op != CMD_NOP) |-> (token_vec == '0), "table edit while probing")

endmodule
`default_nettype wire

// File: rtl/ffba_cell.sv
// One table entry of the allocator: holds a block, probes it, shifts with its neighbours.
`default_nettype none
module ffba_cell #(
  parameter int unsigned Index       = 0,
  parameter int unsigned HeapBytes   = 16777216,
  parameter int unsigned HeaderBytes = 32,
  parameter int unsigned GrainBytes  = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ffba_pkg::entry_t left_i,
  input  wire ffba_pkg::entry_t right_i,
  input  wire ffba_pkg::cmd_t   cmd_i,
  input  wire ffba_pkg::probe_t probe_i,
  output ffba_pkg::probe_t      probe_o,
  output ffba_pkg::entry_t      entry_o
);
  import ffba_pkg::*;

  localparam logic [POS_W-1:0] MyIdx = POS_W'(Index);

  entry_t entry_q, entry_d;
  probe_t probe_q, probe_d;

  logic [REQ_W-1:0] payload_at;
  logic             is_match;
  logic             split_ok;

  assign payload_at = {1'b0, entry_q.start} + REQ_W'(HeaderBytes);
  assign split_ok   = {2'b00, entry_q.size} >=
                      ({1'b0, cmd_i.need} + (REQ_W + 1)'(HeaderBytes + GrainBytes));
  assign is_match   = entry_q.valid &&
                      (cmd_i.is_free ? (payload_at == {1'b0, cmd_i.off})
                                     : (entry_q.free && ({1'b0, entry_q.size} >= cmd_i.need)));

  // Token walks one cell per cycle; the first hit stamps its details into it.
  always_comb begin
    probe_d = '0;
    if (probe_i.active) begin
      probe_d = probe_i;
      if (!probe_i.found && is_match) begin
        probe_d.found     = 1'b1;
        probe_d.idx       = MyIdx;
        probe_d.start     = entry_q.start;
        probe_d.free      = entry_q.free;
        probe_d.split_ok  = split_ok;
        probe_d.prev_free = left_i.valid && left_i.free;
        probe_d.next_free = right_i.valid && right_i.free;
      end
    end
  end

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CMD_SPLIT: begin
        if (MyIdx == cmd_i.pos) begin
          entry_d.size = cmd_i.need[ADDR_W-1:0];
          entry_d.free = 1'b0;
        end else if (MyIdx == cmd_i.pos + POS_W'(1)) begin
          entry_d.valid = 1'b1;
          entry_d.free  = 1'b1;
          entry_d.start = ADDR_W'({1'b0, left_i.start} + REQ_W'(HeaderBytes) + cmd_i.need);
          entry_d.size  = ADDR_W'({1'b0, left_i.size} - cmd_i.need - REQ_W'(HeaderBytes));
        end else if (MyIdx > cmd_i.pos + POS_W'(1)) begin
          entry_d = left_i;
        end
      end
      CMD_TAKE: begin
        if (MyIdx == cmd_i.pos) entry_d.free = 1'b0;
      end
      CMD_SETFREE: begin
        if (MyIdx == cmd_i.pos) entry_d.free = 1'b1;
      end
      CMD_MERGE: begin
        if (MyIdx == cmd_i.pos) begin
          entry_d.size = ADDR_W'({1'b0, entry_q.size} + REQ_W'(HeaderBytes) +
                                 {1'b0, right_i.size});
        end else if (MyIdx > cmd_i.pos) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.valid <= (Index == 0);
      entry_q.free  <= (Index == 0);
      entry_q.start <= '0;
      entry_q.size  <= (Index == 0) ? ADDR_W'(HeapBytes - HeaderBytes) : '0;
      probe_q       <= '0;
    end else begin
      entry_q <= entry_d;
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

// File: test/first_fit_block_allocator_core_tb.sv
// Testbench of the first-fit heap block allocator: directed and random alloc/free traffic.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_core_tb;
  import ffba_pkg::*;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEAP_BYTES   = 16777216;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned GRAIN_BYTES  = 16;
  localparam int unsigned N_RANDOM     = 2000;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam logic        KIND_ALLOC   = 1'b0;
  localparam logic        KIND_FREE    = 1'b1;

  // Shadow heap table and the queue of predicted responses.
  class heap_scoreboard;
    logic [23:0] blk_start[MAX_BLOCKS];
    logic [23:0] blk_size[MAX_BLOCKS];
    bit          blk_free[MAX_BLOCKS];
    int unsigned blk_count;
    out_item_t   pending_q[$];
    int unsigned n_errors;

    function new();
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        blk_start[i] = '0;
        blk_size[i]  = '0;
        blk_free[i]  = 1'b0;
      end
      blk_size[0] = HEAP_BYTES - HEADER_BYTES;
      blk_free[0] = 1'b1;
      blk_count   = 1;
      n_errors    = 0;
    endfunction

    function void drop_entry(int unsigned idx);
      for (int unsigned j = idx; j + 1 < blk_count; j++) begin
        blk_start[j] = blk_start[j+1];
        blk_size[j]  = blk_size[j+1];
        blk_free[j]  = blk_free[j+1];
      end
      blk_count--;
      blk_start[blk_count] = '0;
      blk_size[blk_count]  = '0;
      blk_free[blk_count]  = 1'b0;
    endfunction

    function void open_entry(int unsigned idx, logic [23:0] st, logic [23:0] sz);
      for (int unsigned j = blk_count; j > idx; j--) begin
        blk_start[j] = blk_start[j-1];
        blk_size[j]  = blk_size[j-1];
        blk_free[j]  = blk_free[j-1];
      end
      blk_start[idx] = st;
      blk_size[idx]  = sz;
      blk_free[idx]  = 1'b1;
      blk_count++;
    endfunction

    // Note an accepted request: update the table, queue its response.
    function void note_request(in_item_t it);
      out_item_t   r;
      longint      need, rest;
      int unsigned i;
      r.status         = STS_OK;
      r.granted_offset = '0;
      if (it.kind == KIND_ALLOC) begin
        r.status = STS_ALLOC_FAIL;
        if (it.request_bytes != 0) begin
          need = (longint'(it.request_bytes) + GRAIN_BYTES - 1) / GRAIN_BYTES * GRAIN_BYTES;
          for (i = 0; i < blk_count; i++) begin
            if (blk_free[i] && longint'(blk_size[i]) >= need) begin
              rest = longint'(blk_size[i]) - need;
              if (rest >= HEADER_BYTES + GRAIN_BYTES && blk_count < MAX_BLOCKS) begin
                open_entry(i + 1, 24'(longint'(blk_start[i]) + HEADER_BYTES + need),
                           24'(rest - HEADER_BYTES));
                blk_size[i] = 24'(need);
              end
              blk_free[i]      = 1'b0;
              r.status         = STS_OK;
              r.granted_offset = 24'(longint'(blk_start[i]) + HEADER_BYTES);
              break;
            end
          end
        end
      end else begin
        for (i = 0; i < blk_count; i++)
          if (longint'(blk_start[i]) + HEADER_BYTES == longint'(it.payload_offset)) break;
        if (i >= blk_count || blk_free[i]) begin
          r.status = STS_BAD_FREE;
        end else begin
          blk_free[i] = 1'b1;
          if (i + 1 < blk_count && blk_free[i+1]) begin
            blk_size[i] += HEADER_BYTES + blk_size[i+1];
            drop_entry(i + 1);
          end
          if (i > 0 && blk_free[i-1]) begin
            blk_size[i-1] += HEADER_BYTES + blk_size[i];
            drop_entry(i);
          end
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp;
      if (pending_q.size() == 0) begin
        $error("response with none outstanding: status %0d offset %0h",
               got.status, got.granted_offset);
        n_errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        n_errors++;
      end
      if (got.granted_offset !== exp.granted_offset) begin
        $error("granted_offset: expected %0h, got %0h", exp.granted_offset,
               got.granted_offset);
        n_errors++;
      end
    endfunction
  endclass

  logic      clk_i, rst_ni;
  logic      in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_item_t  in_data_i;
  out_item_t out_data_o;

  heap_scoreboard sb;
  logic [23:0]    live_q[$];   // payload offsets currently granted
  int unsigned    idle_cycles;
  bit             long_hold;   // receiver forced into a long stall
  bit             stim_done;

  first_fit_block_allocator_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Transfers are noted and checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(in_data_i);
        if (in_data_i.kind == KIND_ALLOC && sb.pending_q[$].status == STS_OK)
          live_q.push_back(sb.pending_q[$].granted_offset);
      end
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: own stall pattern, long hold-off on request.
  initial begin
    int unsigned mode;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i = 1'b0;
        repeat (600) @(negedge clk_i);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 9);
      if (mode < 3) out_ready_i = 1'b1;
      else out_ready_i = ($urandom_range(0, 3) != 0);
    end
  end

  // Offer one request and hold it until it transfers.
  task automatic send_req(logic kind, logic [24:0] req, logic [23:0] off);
    in_valid_i              = 1'b1;
    in_data_i.kind          = kind;
    in_data_i.request_bytes = req;
    in_data_i.payload_offset = off;
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_alloc(logic [24:0] req);
    send_req(KIND_ALLOC, req, 24'($urandom));
  endtask

  task automatic send_free(logic [23:0] off);
    send_req(KIND_FREE, 25'($urandom), off);
  endtask

  // Free a random live block (or a bogus address now and then).
  task automatic free_some();
    int unsigned k;
    logic [23:0] off;
    if (live_q.size() == 0 || $urandom_range(0, 19) == 0) begin
      send_free(24'($urandom));
    end else begin
      k   = $urandom_range(0, live_q.size() - 1);
      off = live_q[k];
      live_q.delete(k);
      send_free(off);
      if ($urandom_range(0, 15) == 0) send_free(off);  // double free
    end
  endtask

  function automatic logic [24:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 25'($urandom_range(1, 4096));
    if (r < 90) return 25'($urandom_range(1, 1 << 18));
    if (r < 97) return 25'($urandom_range(1, HEAP_BYTES));
    return 25'($urandom);
  endfunction

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned burst;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idle_cycles = 0;
    long_hold   = 1'b0;
    stim_done   = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero size, oversize, tiny, exact remainder, frees with merges.
    send_alloc(25'd0);
    send_alloc(25'(HEAP_BYTES));
    send_alloc(25'h1FF_FFFF);
    send_alloc(25'd1);
    send_alloc(25'd16);
    send_alloc(25'd17);
    send_free(24'd0);
    send_free(24'hFF_FFFF);
    send_free(24'd33);
    send_free(24'd32);
    send_free(24'd32);           // already free
    send_free(24'd80);           // merges with free predecessor
    drain();
    // Whole heap, then table-full case: fill with tiny blocks.
    send_alloc(25'(HEAP_BYTES - HEADER_BYTES));
    send_alloc(25'd1);
    drain();
    foreach (live_q[i]) send_free(live_q[i]);
    live_q.delete();
    drain();
    for (int i = 0; i < 66; i++) send_alloc(25'd16);
    drain();
    send_free(live_q[10]);
    send_free(live_q[12]);
    send_free(live_q[11]);       // merges both sides
    live_q.delete(10);
    live_q.delete(10);
    live_q.delete(10);
    send_alloc(25'd80);          // takes the merged block whole; the rest is too small to split
    drain();
    foreach (live_q[i]) send_free(live_q[i]);
    live_q.delete();
    drain();

    // Random bursts; one long receiver hold-off mid-way.
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, n++) begin
        if (n == N_RANDOM / 2) long_hold = 1'b1;
        if (live_q.size() < 8 || ($urandom_range(0, 99) < 55 && live_q.size() < 70))
          send_alloc(pick_size());
        else
          free_some();
      end
      if (n % 400 < 30) drain();   // sender waits for every response
      else repeat ($urandom_range(0, 40)) @(negedge clk_i);
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
